// ----- design/dvfc_pkg.sv -----
// Package with the sizes, types and helper functions of the distinct value frequency counter.
`default_nettype none
package dvfc_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int COUNT_BITS  = 16;
  localparam int VALUE_BITS  = 32;
  localparam int OCC_BITS    = 16;
  localparam int ADDR_BITS   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int USED_BITS   = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_BITS  = VALUE_BITS + COUNT_BITS;
  localparam int OUT_BITS    = ((VALUE_BITS + OCC_BITS + 7) / 8) * 8;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [OCC_BITS-1:0]   occ_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [USED_BITS-1:0]  used_t;
  typedef logic [ENTRY_BITS-1:0] entry_t;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_SCAN    = 5'b00010,
    ST_EMIT_RD = 5'b00100,
    ST_EMIT_LD = 5'b01000,
    ST_EMIT_WT = 5'b10000
  } state_t;

  // Increment that stops at the largest count.
  function automatic count_t count_inc(input count_t c);
    if (c == '1) begin
      return c;
    end
    return c + count_t'(1);
  endfunction

  // Narrows a stored count to the output field, saturating when it does not fit.
  function automatic occ_t occ_sat(input count_t c);
    logic [31:0] wide;
    wide = 32'(c);
    if (wide > 32'(2 ** OCC_BITS - 1)) begin
      return '1;
    end
    return wide[OCC_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- design/distinct_value_frequency_counter.sv -----
// Top level of the distinct value frequency counter: entry memory, scan and emit control.
// An item is scanned over the N stored entries: one memory read per stored key,
// issued each cycle, compared in the next; a match, an append or a full table ends the scan.
// At end of run each entry is read, loaded and transferred, the transfer waiting out any output stall.
// A single item-at-a-time sequencer owns the entry memory, with one read and one write port.
// Synchronous active-low reset clears the control state, fill count and overflow flag;
// the entry memory is not cleared, only entries below the fill count are ever read.
`default_nettype none
module distinct_value_frequency_counter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] sample_value
  input  wire logic        in_tlast,   // end_of_run
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [31:0] distinct_value, [47:32] occurrences
  output logic             out_tlast,  // final_entry
  output logic             out_tuser   // table_overflowed
);

  dvfc_pkg::entry_t mem [dvfc_pkg::TABLE_DEPTH];
  dvfc_pkg::entry_t rd_data_r;
  dvfc_pkg::addr_t  rd_addr;
  logic             wr_en;
  dvfc_pkg::addr_t  wr_addr;
  dvfc_pkg::entry_t wr_data;

  dvfc_pkg::state_t state_r, state_nxt;
  dvfc_pkg::used_t  used_r, used_nxt;
  logic             ovf_r, ovf_nxt;
  dvfc_pkg::value_t val_r, val_nxt;
  logic             last_r, last_nxt;
  dvfc_pkg::used_t  idx_r, idx_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  dvfc_pkg::addr_t  cmp_idx_r, cmp_idx_nxt;

  logic             out_vld_r, out_vld_nxt;
  dvfc_pkg::value_t out_val_r, out_val_nxt;
  dvfc_pkg::occ_t   out_occ_r, out_occ_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  dvfc_pkg::value_t rd_key;
  dvfc_pkg::count_t rd_cnt;

  assign rd_key = rd_data_r[dvfc_pkg::ENTRY_BITS-1:dvfc_pkg::COUNT_BITS];
  assign rd_cnt = rd_data_r[dvfc_pkg::COUNT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt    = state_r;
    used_nxt     = used_r;
    ovf_nxt      = ovf_r;
    val_nxt      = val_r;
    last_nxt     = last_r;
    idx_nxt      = idx_r;
    cmp_vld_nxt  = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    out_vld_nxt  = out_vld_r;
    out_val_nxt  = out_val_r;
    out_occ_nxt  = out_occ_r;
    out_last_nxt = out_last_r;
    out_ovf_nxt  = out_ovf_r;
    rd_addr      = idx_r[dvfc_pkg::ADDR_BITS-1:0];
    wr_en        = 1'b0;
    wr_addr      = used_r[dvfc_pkg::ADDR_BITS-1:0];
    wr_data      = {val_r, dvfc_pkg::count_t'(1)};
    in_tready    = (state_r == dvfc_pkg::ST_IDLE);

    unique case (state_r)
      dvfc_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          val_nxt   = in_tdata;
          last_nxt  = in_tlast;
          idx_nxt   = '0;
          state_nxt = dvfc_pkg::ST_SCAN;
        end
      end
      dvfc_pkg::ST_SCAN: begin
        priority if (cmp_vld_r && (rd_key == val_r)) begin
          // Repeat of a stored value: write back its incremented count.
          wr_en     = 1'b1;
          wr_addr   = cmp_idx_r;
          wr_data   = {rd_key, dvfc_pkg::count_inc(rd_cnt)};
          idx_nxt   = '0;
          state_nxt = last_r ? dvfc_pkg::ST_EMIT_RD : dvfc_pkg::ST_IDLE;
        end else if (idx_r < used_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = idx_r[dvfc_pkg::ADDR_BITS-1:0];
          idx_nxt     = idx_r + dvfc_pkg::used_t'(1);
        end else begin
          // Every stored key has been compared without a match.
          if (used_r == dvfc_pkg::used_t'(dvfc_pkg::TABLE_DEPTH)) begin
            ovf_nxt = 1'b1;
          end else begin
            wr_en    = 1'b1;
            used_nxt = used_r + dvfc_pkg::used_t'(1);
          end
          idx_nxt   = '0;
          state_nxt = last_r ? dvfc_pkg::ST_EMIT_RD : dvfc_pkg::ST_IDLE;
        end
      end
      dvfc_pkg::ST_EMIT_RD: begin
        state_nxt = dvfc_pkg::ST_EMIT_LD;
      end
      dvfc_pkg::ST_EMIT_LD: begin
        out_vld_nxt  = 1'b1;
        out_val_nxt  = rd_key;
        out_occ_nxt  = dvfc_pkg::occ_sat(rd_cnt);
        out_last_nxt = ((idx_r + dvfc_pkg::used_t'(1)) == used_r);
        out_ovf_nxt  = ovf_r;
        state_nxt    = dvfc_pkg::ST_EMIT_WT;
      end
      dvfc_pkg::ST_EMIT_WT: begin
        if (out_tready) begin
          out_vld_nxt = 1'b0;
          if (out_last_r) begin
            // The whole table has been sent: start the next run empty.
            used_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = dvfc_pkg::ST_IDLE;
          end else begin
            idx_nxt   = idx_r + dvfc_pkg::used_t'(1);
            state_nxt = dvfc_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = dvfc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= dvfc_pkg::ST_IDLE;
      used_r    <= '0;
      ovf_r     <= 1'b0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      used_r    <= used_nxt;
      ovf_r     <= ovf_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    last_r     <= last_nxt;
    idx_r      <= idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    out_val_r  <= out_val_nxt;
    out_occ_r  <= out_occ_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_occ_r, out_val_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule
`default_nettype wire
